// File: design/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants of the piece block scoreboard.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int BLOCK_SIZE = 16384;
  localparam int MAX_BLOCKS = 64;

  localparam int BLK_BITS  = $clog2(BLOCK_SIZE);
  localparam int IDX_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int LEN_W     = 21;
  localparam int OFF_W     = 20;
  localparam int SIZE_W    = 15;
  localparam int PIECE_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(MAX_BLOCKS * BLOCK_SIZE);
  localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(MAX_BLOCKS);
  localparam logic [LEN_W-1:0]  TOTAL_MAX = {LEN_W{1'b1}};
  localparam logic [SIZE_W-1:0] BLK_LEN   = SIZE_W'(BLOCK_SIZE);

  localparam logic [CFG_IDX_W-1:0] REG_PIECE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_NUMBER = 1'b1;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_SAVE    = 2'd1,
    KIND_RESET   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [OFF_W-1:0]   save_offset;
    logic [SIZE_W-1:0]  data_size;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]   eff_length;
    logic [CNT_W-1:0]   blk_count;
    logic [PIECE_W-1:0] piece_number;
    logic               clear;
  } cfg_t;

  typedef struct packed {
    logic               granted;
    logic [OFF_W-1:0]   grant_offset;
    logic [SIZE_W-1:0]  grant_length;
    logic [PIECE_W-1:0] grant_piece;
    logic               save_accepted;
    logic               all_retrieved;
    logic               any_pending;
    logic [LEN_W-1:0]   bytes_done;
  } result_t;

endpackage

// File: design/pbs_cfg.sv
// ----------------------------------------------------------------------------
// pbs_cfg
// Configuration registers with clamped piece length and block count.
// ----------------------------------------------------------------------------
module pbs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbs_pkg::CFG_W-1:0]     cfg_data,
  output pbs_pkg::cfg_t                 cfg
);
  import pbs_pkg::*;

  logic [LEN_W-1:0]   eff_length;
  logic [CNT_W-1:0]   blk_count;
  logic [PIECE_W-1:0] piece_number;
  logic               clear;

  logic [LEN_W-1:0]   len_in;
  logic [LEN_W-1:0]   len_clamped;
  logic [LEN_W:0]     len_round;

  always_comb begin
    len_in      = cfg_data[LEN_W-1:0];
    len_clamped = (len_in > LEN_CAP) ? LEN_CAP : len_in;
    len_round   = {1'b0, len_clamped} + (LEN_W+1)'(BLOCK_SIZE - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_length   <= LEN_CAP;
      blk_count    <= CNT_RESET;
      piece_number <= '0;
      clear        <= 1'b0;
    end else begin
      clear <= 1'b0;
      if (cfg_we && cfg_index == REG_PIECE_LENGTH) begin
        eff_length <= len_clamped;
        blk_count  <= len_round[CNT_W+BLK_BITS-1:BLK_BITS];
        clear      <= 1'b1;
      end
      if (cfg_we && cfg_index == REG_PIECE_NUMBER) begin
        piece_number <= cfg_data[PIECE_W-1:0];
      end
    end
  end

  assign cfg = '{eff_length: eff_length, blk_count: blk_count,
                 piece_number: piece_number, clear: clear};

endmodule

// File: design/pbs_in_stage.sv
// ----------------------------------------------------------------------------
// pbs_in_stage
// Input register for one item, with stall toward the sender.
// ----------------------------------------------------------------------------
module pbs_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 kind,
  input  logic [pbs_pkg::OFF_W-1:0]  save_offset,
  input  logic [pbs_pkg::SIZE_W-1:0] data_size,
  input  logic                       advance,
  output logic                       held_valid,
  output pbs_pkg::item_t             held
);
  import pbs_pkg::*;

  logic accept;

  assign item_stall = held_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= '{kind: kind_t'(kind), save_offset: save_offset, data_size: data_size};
    end
  end

endmodule

// File: design/pbs_core.sv
// ----------------------------------------------------------------------------
// pbs_core
// Block state vectors, byte total, request and save logic, result register.
// ----------------------------------------------------------------------------
module pbs_core (
  input  logic              clk,
  input  logic              rst,
  input  pbs_pkg::cfg_t     cfg,
  input  logic              held_valid,
  input  pbs_pkg::item_t    held,
  input  logic              advance,
  output logic              result_valid,
  output pbs_pkg::result_t  result
);
  import pbs_pkg::*;

  logic [MAX_BLOCKS-1:0] pend;
  logic [MAX_BLOCKS-1:0] ret;
  logic [LEN_W-1:0]      total;

  logic [MAX_BLOCKS-1:0] pend_next;
  logic [MAX_BLOCKS-1:0] ret_next;
  logic [LEN_W-1:0]      total_next;
  logic [MAX_BLOCKS-1:0] mask;
  logic [MAX_BLOCKS-1:0] miss;
  logic [IDX_W-1:0]      idx;
  logic                  found;
  logic [OFF_W-1:0]      g_off;
  logic [LEN_W-1:0]      rest;
  logic [IDX_W-1:0]      sidx;
  logic                  hit;
  logic [LEN_W:0]        sum;
  logic                  do_step;
  result_t               res_next;

  assign do_step = held_valid && advance;

  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      mask[i] = (CNT_W'(i) < cfg.blk_count);
    end
    miss  = ~pend & ~ret & mask;
    found = |miss;
    idx   = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (miss[i]) idx = IDX_W'(i);
    end
    g_off = OFF_W'({idx, {BLK_BITS{1'b0}}});
    rest  = cfg.eff_length - LEN_W'(g_off);

    sidx = held.save_offset[OFF_W-1:BLK_BITS];
    hit  = (held.save_offset[BLK_BITS-1:0] == '0) && ({1'b0, sidx} < cfg.blk_count)
           && pend[sidx];
    sum  = {1'b0, total} + (LEN_W+1)'(held.data_size);

    pend_next  = pend;
    ret_next   = ret;
    total_next = total;
    res_next   = '0;

    case (held.kind)
      KIND_REQUEST: begin
        if (found) begin
          pend_next[idx]        = 1'b1;
          res_next.granted      = 1'b1;
          res_next.grant_offset = g_off;
          res_next.grant_length = (rest < LEN_W'(BLOCK_SIZE)) ? rest[SIZE_W-1:0] : BLK_LEN;
          res_next.grant_piece  = cfg.piece_number;
        end
      end
      KIND_SAVE: begin
        if (hit) begin
          pend_next[sidx]        = 1'b0;
          ret_next[sidx]         = 1'b1;
          total_next             = sum[LEN_W] ? TOTAL_MAX : sum[LEN_W-1:0];
          res_next.save_accepted = 1'b1;
        end
      end
      KIND_RESET: begin
        pend_next  = '0;
        ret_next   = '0;
        total_next = '0;
      end
      default: begin
      end
    endcase

    res_next.all_retrieved = ((ret_next & mask) == mask);
    res_next.any_pending   = |pend_next;
    res_next.bytes_done    = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      pend  <= '0;
      ret   <= '0;
      total <= '0;
    end else if (do_step) begin
      pend  <= pend_next;
      ret   <= ret_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      result <= res_next;
    end
  end

endmodule

// File: design/piece_block_scoreboard_unit.sv
// ----------------------------------------------------------------------------
// piece_block_scoreboard_unit
// Download scoreboard of one piece: grants missing blocks, takes saves.
//
//   channel   handshake                   payload
//   item      item_valid / item_stall     kind, save_offset, data_size
//   result    result_valid / result_stall granted ... bytes_done
//   config    cfg_we                      cfg_index, cfg_data
//
// An item is accepted into the input register and then moves on to the result register;
// one item per cycle is taken while the result side is not stalled.
// The lowest-missing-block priority encoder over the 64 state bits sets
// the cycle time. Reset clears all blocks to missing, the byte count to
// zero, piece length to the maximum. A stall on results holds both stages.
// ----------------------------------------------------------------------------
module piece_block_scoreboard_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    kind,
  input  logic [pbs_pkg::OFF_W-1:0]     save_offset,
  input  logic [pbs_pkg::SIZE_W-1:0]    data_size,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          granted,
  output logic [pbs_pkg::OFF_W-1:0]     grant_offset,
  output logic [pbs_pkg::SIZE_W-1:0]    grant_length,
  output logic [pbs_pkg::PIECE_W-1:0]   grant_piece,
  output logic                          save_accepted,
  output logic                          all_retrieved,
  output logic                          any_pending,
  output logic [pbs_pkg::LEN_W-1:0]     bytes_done
);
  import pbs_pkg::*;

  cfg_t    cfg;
  item_t   held;
  logic    held_valid;
  logic    advance;
  result_t result;

  assign advance = !result_valid || !result_stall;

  pbs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbs_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .save_offset (save_offset),
    .data_size   (data_size),
    .advance     (advance),
    .held_valid  (held_valid),
    .held        (held)
  );

  pbs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .held_valid   (held_valid),
    .held         (held),
    .advance      (advance),
    .result_valid (result_valid),
    .result       (result)
  );

  assign granted       = result.granted;
  assign grant_offset  = result.grant_offset;
  assign grant_length  = result.grant_length;
  assign grant_piece   = result.grant_piece;
  assign save_accepted = result.save_accepted;
  assign all_retrieved = result.all_retrieved;
  assign any_pending   = result.any_pending;
  assign bytes_done    = result.bytes_done;

endmodule
